[src/cr3_pkg.sv]
// shared types, constants and microprogram of the three-body derivative core
package cr3_pkg;

  localparam int FRAC_BITS = 47;
  localparam int PROG_LEN = 256;

  localparam logic [63:0] ONE_Q = 64'(1) << FRAC_BITS;
  localparam logic [63:0] TWO_Q = 64'(2) << FRAC_BITS;
  localparam logic [63:0] MAX_Q = {1'b0, {63{1'b1}}};
  localparam logic [63:0] MIN_Q = {1'b1, {63{1'b0}}};

  localparam logic [0:0] CFG_MASS_RATIO = 1'd0;
  localparam logic [0:0] CFG_THRUST_LEVEL = 1'd1;

  localparam logic [1:0] FAULT_OK = 2'd0;
  localparam logic [1:0] FAULT_ZERO = 2'd1;
  localparam logic [1:0] FAULT_SAT = 2'd2;

  localparam logic [7:0] ST_START = 8'd0;
  localparam logic [7:0] COL_START = 8'd184;

  // operand space: item fields, constants, scratch, jacobian, result rows
  localparam logic [6:0] R_X = 7'd0;
  localparam logic [6:0] R_Y = 7'd1;
  localparam logic [6:0] R_Z = 7'd2;
  localparam logic [6:0] R_VX = 7'd3;
  localparam logic [6:0] R_VY = 7'd4;
  localparam logic [6:0] R_VZ = 7'd5;
  localparam logic [6:0] R_M = 7'd6;
  localparam logic [6:0] R_ZERO = 7'd7;
  localparam logic [6:0] R_ONE = 7'd8;
  localparam logic [6:0] R_TWO = 7'd9;
  localparam logic [6:0] R_MU = 7'd10;
  localparam logic [6:0] R_THR = 7'd11;
  localparam logic [6:0] R_OM = 7'd16;
  localparam logic [6:0] R_PX = 7'd17;
  localparam logic [6:0] R_QX = 7'd18;
  localparam logic [6:0] R_U0 = 7'd19;
  localparam logic [6:0] R_U1 = 7'd20;
  localparam logic [6:0] R_T1 = 7'd21;
  localparam logic [6:0] R_T2 = 7'd22;
  localparam logic [6:0] R_YZ2 = 7'd23;
  localparam logic [6:0] R_D = 7'd24;
  localparam logic [6:0] R_R = 7'd25;
  localparam logic [6:0] R_V = 7'd26;
  localparam logic [6:0] R_ID = 7'd27;
  localparam logic [6:0] R_IR = 7'd28;
  localparam logic [6:0] R_IV = 7'd29;
  localparam logic [6:0] R_TM = 7'd30;
  localparam logic [6:0] R_ID2 = 7'd31;
  localparam logic [6:0] R_ID3 = 7'd32;
  localparam logic [6:0] R_ID5 = 7'd33;
  localparam logic [6:0] R_IR2 = 7'd34;
  localparam logic [6:0] R_IR3 = 7'd35;
  localparam logic [6:0] R_IR5 = 7'd36;
  localparam logic [6:0] R_GA = 7'd37;
  localparam logic [6:0] R_GB = 7'd38;
  localparam logic [6:0] R_HD = 7'd39;
  localparam logic [6:0] R_HR = 7'd40;
  localparam logic [6:0] R_K1 = 7'd41;
  localparam logic [6:0] R_K3 = 7'd42;
  localparam logic [6:0] R_A = 7'd43;
  localparam logic [6:0] R_G = 7'd44;
  localparam logic [6:0] R_S = 7'd45;
  localparam logic [6:0] R_TJ = 7'd46;
  localparam logic [6:0] R_JAC = 7'd64;
  localparam logic [6:0] R_JAC_LAST = 7'd81;
  localparam logic [6:0] R_OUT = 7'd82;
  localparam logic [6:0] R_OUT_LAST = 7'd84;

  typedef enum logic [2:0] {OP_END, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_SQRT} op_t;

  typedef enum logic [2:0] {AL_IDLE, AL_MUL, AL_DIV, AL_SQRT, AL_FIN} alu_state_t;

  typedef enum logic [2:0] {B_IDLE, B_FETCH, B_OPER, B_EXEC, B_DONE} back_state_t;

  typedef struct packed {
    op_t op;
    logic [6:0] dst;
    logic [6:0] src_a;
    logic [6:0] src_b;
  } instr_t;

  typedef instr_t [PROG_LEN-1:0] prog_t;

  typedef struct packed {
    logic action;
    logic [5:0][63:0] elem;
    logic [62:0] mass;
  } item_t;

  typedef struct packed {
    item_t item;
    logic [7:0] start_pc;
  } qentry_t;

  typedef struct packed {
    logic [46:0] mu;
    logic [47:0] thr;
  } cfg_t;

  typedef struct packed {
    logic start;
    op_t op;
    logic [63:0] a;
    logic [63:0] b;
  } alu_req_t;

  typedef struct packed {
    logic done;
    logic [63:0] result;
    logic sat;
    logic zero;
  } alu_rsp_t;

  function automatic instr_t mk(op_t o, logic [6:0] d, logic [6:0] a, logic [6:0] b);
    mk = '{o, d, a, b};
  endfunction

  function automatic prog_t build_prog();
    prog_t p;
    int n;
    int i;
    int j;
    logic [6:0] uu [3];
    logic [6:0] pd [3];
    logic [6:0] pr [3];
    logic [6:0] asrc;
    logic [6:0] jd;
    logic [6:0] sd;
    p = '0;
    uu[0] = R_U0; uu[1] = R_U1; uu[2] = R_VZ;
    pd[0] = R_PX; pd[1] = R_Y; pd[2] = R_Z;
    pr[0] = R_QX; pr[1] = R_Y; pr[2] = R_Z;
    n = int'(ST_START);
    p[n] = mk(OP_SUB, R_OM, R_ONE, R_MU); n++;
    p[n] = mk(OP_ADD, R_PX, R_X, R_MU); n++;
    p[n] = mk(OP_SUB, R_QX, R_PX, R_ONE); n++;
    p[n] = mk(OP_SUB, R_U0, R_VX, R_Y); n++;
    p[n] = mk(OP_ADD, R_U1, R_VY, R_X); n++;
    p[n] = mk(OP_MUL, R_T1, R_Y, R_Y); n++;
    p[n] = mk(OP_MUL, R_T2, R_Z, R_Z); n++;
    p[n] = mk(OP_ADD, R_YZ2, R_T1, R_T2); n++;
    p[n] = mk(OP_MUL, R_T1, R_PX, R_PX); n++;
    p[n] = mk(OP_ADD, R_T1, R_T1, R_YZ2); n++;
    p[n] = mk(OP_SQRT, R_D, R_T1, R_ZERO); n++;
    p[n] = mk(OP_MUL, R_T1, R_QX, R_QX); n++;
    p[n] = mk(OP_ADD, R_T1, R_T1, R_YZ2); n++;
    p[n] = mk(OP_SQRT, R_R, R_T1, R_ZERO); n++;
    p[n] = mk(OP_MUL, R_T1, R_U0, R_U0); n++;
    p[n] = mk(OP_MUL, R_T2, R_U1, R_U1); n++;
    p[n] = mk(OP_ADD, R_T1, R_T1, R_T2); n++;
    p[n] = mk(OP_MUL, R_T2, R_VZ, R_VZ); n++;
    p[n] = mk(OP_ADD, R_T1, R_T1, R_T2); n++;
    p[n] = mk(OP_SQRT, R_V, R_T1, R_ZERO); n++;
    p[n] = mk(OP_DIV, R_ID, R_ONE, R_D); n++;
    p[n] = mk(OP_DIV, R_IR, R_ONE, R_R); n++;
    p[n] = mk(OP_DIV, R_IV, R_ONE, R_V); n++;
    p[n] = mk(OP_DIV, R_TM, R_THR, R_M); n++;
    p[n] = mk(OP_MUL, R_ID2, R_ID, R_ID); n++;
    p[n] = mk(OP_MUL, R_ID3, R_ID2, R_ID); n++;
    p[n] = mk(OP_MUL, R_ID5, R_ID3, R_ID2); n++;
    p[n] = mk(OP_MUL, R_IR2, R_IR, R_IR); n++;
    p[n] = mk(OP_MUL, R_IR3, R_IR2, R_IR); n++;
    p[n] = mk(OP_MUL, R_IR5, R_IR3, R_IR2); n++;
    p[n] = mk(OP_MUL, R_GA, R_OM, R_ID3); n++;
    p[n] = mk(OP_MUL, R_GB, R_MU, R_IR3); n++;
    p[n] = mk(OP_MUL, R_HD, R_OM, R_ID5); n++;
    p[n] = mk(OP_ADD, R_T1, R_HD, R_HD); n++;
    p[n] = mk(OP_ADD, R_HD, R_T1, R_HD); n++;
    p[n] = mk(OP_MUL, R_HR, R_MU, R_IR5); n++;
    p[n] = mk(OP_ADD, R_T1, R_HR, R_HR); n++;
    p[n] = mk(OP_ADD, R_HR, R_T1, R_HR); n++;
    p[n] = mk(OP_MUL, R_K1, R_TM, R_IV); n++;
    p[n] = mk(OP_MUL, R_T1, R_IV, R_IV); n++;
    p[n] = mk(OP_MUL, R_K3, R_K1, R_T1); n++;
    // thrust partials
    for (i = 0; i < 3; i++) begin
      for (j = 0; j < 3; j++) begin
        p[n] = mk(OP_MUL, R_T1, uu[i], uu[j]); n++;
        if (i == j) begin
          p[n] = mk(OP_MUL, R_T1, R_K3, R_T1); n++;
          p[n] = mk(OP_SUB, 7'(R_TJ + i * 3 + j), R_T1, R_K1); n++;
        end else begin
          p[n] = mk(OP_MUL, 7'(R_TJ + i * 3 + j), R_K3, R_T1); n++;
        end
      end
    end
    for (i = 0; i < 3; i++) begin
      asrc = R_A;
      if (i == 0) begin
        p[n] = mk(OP_ADD, R_T1, R_VY, R_VY); n++;
        p[n] = mk(OP_ADD, R_A, R_T1, R_X); n++;
      end else if (i == 1) begin
        p[n] = mk(OP_ADD, R_T1, R_VX, R_VX); n++;
        p[n] = mk(OP_SUB, R_A, R_Y, R_T1); n++;
      end else begin
        asrc = R_ZERO;
      end
      p[n] = mk(OP_MUL, R_T1, R_GA, pd[i]); n++;
      p[n] = mk(OP_SUB, R_A, asrc, R_T1); n++;
      p[n] = mk(OP_MUL, R_T1, R_GB, pr[i]); n++;
      p[n] = mk(OP_SUB, R_A, R_A, R_T1); n++;
      p[n] = mk(OP_MUL, R_T1, R_K1, uu[i]); n++;
      p[n] = mk(OP_SUB, 7'(R_OUT + i), R_A, R_T1); n++;
      for (j = 0; j < 6; j++) begin
        jd = 7'(R_JAC + i * 6 + j);
        if (j < 3) begin
          p[n] = mk(OP_MUL, R_T1, pd[i], pd[j]); n++;
          p[n] = mk(OP_MUL, R_T1, R_HD, R_T1); n++;
          p[n] = mk(OP_MUL, R_T2, pr[i], pr[j]); n++;
          p[n] = mk(OP_MUL, R_T2, R_HR, R_T2); n++;
          p[n] = mk(OP_ADD, R_G, R_T1, R_T2); n++;
          if (i == j) begin
            p[n] = mk(OP_SUB, R_G, R_G, R_GA); n++;
            p[n] = mk(OP_SUB, R_G, R_G, R_GB); n++;
            if (i < 2) begin
              p[n] = mk(OP_ADD, R_G, R_G, R_ONE); n++;
            end
          end
          if (j == 0) begin
            p[n] = mk(OP_ADD, R_G, R_G, 7'(R_TJ + i * 3 + 1)); n++;
          end
          if (j == 1) begin
            p[n] = mk(OP_SUB, R_G, R_G, 7'(R_TJ + i * 3)); n++;
          end
          p[n] = mk(OP_ADD, jd, R_G, R_ZERO); n++;
        end else if (i == 0 && j == 4) begin
          p[n] = mk(OP_ADD, jd, 7'(R_TJ + j - 3), R_TWO); n++;
        end else if (i == 1 && j == 3) begin
          p[n] = mk(OP_SUB, jd, 7'(R_TJ + 3), R_TWO); n++;
        end else begin
          p[n] = mk(OP_ADD, jd, 7'(R_TJ + i * 3 + j - 3), R_ZERO); n++;
        end
      end
    end
    // stm column: stored rows times the column
    n = int'(COL_START);
    for (i = 0; i < 3; i++) begin
      for (j = 0; j < 6; j++) begin
        sd = (j == 5) ? 7'(R_OUT + i) : R_S;
        p[n] = mk(OP_MUL, R_T1, 7'(R_JAC + i * 6 + j), 7'(R_X + j)); n++;
        p[n] = mk(OP_ADD, sd, (j == 0) ? R_ZERO : R_S, R_T1); n++;
      end
    end
    return p;
  endfunction

  localparam prog_t PROG = build_prog();

endpackage

[src/cr3_front.sv]
// input beat acceptance, item classification and the two-entry item queue
module cr3_front import cr3_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [447:0] in_tdata,
  input  logic [0:0]   in_tuser,
  output logic         q_valid,
  output qentry_t      q_entry,
  input  logic         q_pop
);

  qentry_t q_mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       push;
  qentry_t    in_entry;

  always_comb begin
    in_entry.item.action = in_tuser[0];
    in_entry.item.elem = in_tdata[383:0];
    in_entry.item.mass = in_tdata[446:384];
    in_entry.start_pc = in_tuser[0] ? COL_START : ST_START;
  end

  assign in_tready = (count_r != 2'd2);
  assign push = in_tvalid && in_tready;
  assign q_valid = (count_r != 2'd0);
  assign q_entry = q_mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ q_pop;
    count_nxt = count_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= in_entry;
    end
  end

endmodule

[src/cr3_alu.sv]
// shared multi-cycle fixed-point unit: saturating add/sub, multiply, divide, square root
module cr3_alu import cr3_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  alu_req_t req,
  output alu_rsp_t rsp
);

  localparam logic [127:0] HALF_W = 128'(1) << (FRAC_BITS - 1);

  alu_state_t   state_r, state_nxt;
  op_t          op_r, op_nxt;
  logic         neg_r, neg_nxt;
  logic [63:0]  mb_r, mb_nxt;
  logic [63:0]  ma_r, ma_nxt;
  logic [127:0] acc_r, acc_nxt;
  logic [127:0] num_r, num_nxt;
  logic [67:0]  rem_r, rem_nxt;
  logic [6:0]   cnt_r, cnt_nxt;
  logic         done_r, done_nxt;
  logic [63:0]  res_r, res_nxt;
  logic         sat_r, sat_nxt;
  logic         zero_r, zero_nxt;

  logic [64:0]  s65;
  logic [31:0]  ah, bh;
  logic [63:0]  pp;
  logic [6:0]   shamt;
  logic [67:0]  rem_sh, trial;
  logic [63:0]  root;
  logic [127:0] wq;
  logic [64:0]  fw;

  function automatic logic [63:0] mag(logic [63:0] v);
    return v[63] ? (~v + 64'd1) : v;
  endfunction

  // saturate a 128-bit magnitude with sign, {sat, value}
  function automatic logic [64:0] from_wide(logic [127:0] w, logic neg);
    logic [63:0] m;
    m = w[63:0];
    if (w[127:64] != 64'd0) return {1'b1, neg ? MIN_Q : MAX_Q};
    if (neg) begin
      if (m > MIN_Q) return {1'b1, MIN_Q};
      return {1'b0, ~m + 64'd1};
    end
    if (m[63]) return {1'b1, MAX_Q};
    return {1'b0, m};
  endfunction

  always_comb begin
    state_nxt = state_r;
    op_nxt = op_r;
    neg_nxt = neg_r;
    ma_nxt = ma_r;
    mb_nxt = mb_r;
    acc_nxt = acc_r;
    num_nxt = num_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    done_nxt = 1'b0;
    res_nxt = res_r;
    sat_nxt = sat_r;
    zero_nxt = zero_r;
    s65 = '0;
    ah = '0;
    bh = '0;
    pp = '0;
    shamt = '0;
    rem_sh = '0;
    trial = '0;
    root = '0;
    wq = '0;
    fw = '0;
    case (state_r)
      AL_IDLE: begin
        if (req.start) begin
          op_nxt = req.op;
          neg_nxt = req.a[63] ^ req.b[63];
          ma_nxt = mag(req.a);
          mb_nxt = mag(req.b);
          acc_nxt = '0;
          rem_nxt = '0;
          cnt_nxt = '0;
          sat_nxt = 1'b0;
          zero_nxt = 1'b0;
          case (req.op)
            OP_ADD, OP_SUB: begin
              if (req.op == OP_ADD) s65 = {req.a[63], req.a} + {req.b[63], req.b};
              else s65 = {req.a[63], req.a} - {req.b[63], req.b};
              done_nxt = 1'b1;
              if (s65[64] != s65[63]) begin
                sat_nxt = 1'b1;
                res_nxt = s65[64] ? MIN_Q : MAX_Q;
              end else begin
                res_nxt = s65[63:0];
              end
            end
            OP_MUL: state_nxt = AL_MUL;
            OP_DIV: begin
              if (req.b == 64'd0) begin
                zero_nxt = 1'b1;
                res_nxt = req.a[63] ? MIN_Q : MAX_Q;
                done_nxt = 1'b1;
              end else begin
                num_nxt = 128'(mag(req.a)) << FRAC_BITS;
                state_nxt = AL_DIV;
              end
            end
            OP_SQRT: begin
              if (req.a[63] || req.a == 64'd0) begin
                res_nxt = '0;
                done_nxt = 1'b1;
              end else begin
                num_nxt = 128'(req.a) << FRAC_BITS;
                state_nxt = AL_SQRT;
              end
            end
            default: begin
              res_nxt = '0;
              done_nxt = 1'b1;
            end
          endcase
        end
      end
      AL_MUL: begin
        ah = cnt_r[1] ? ma_r[63:32] : ma_r[31:0];
        bh = cnt_r[0] ? mb_r[63:32] : mb_r[31:0];
        pp = ah * bh;
        shamt = ({6'd0, cnt_r[1]} + {6'd0, cnt_r[0]}) << 5;
        acc_nxt = acc_r + (128'(pp) << shamt);
        cnt_nxt = cnt_r + 7'd1;
        if (cnt_r[1:0] == 2'd3) state_nxt = AL_FIN;
      end
      AL_DIV: begin
        rem_sh = {rem_r[66:0], num_r[127]};
        num_nxt = num_r << 1;
        if (rem_sh >= 68'(mb_r)) begin
          rem_nxt = rem_sh - 68'(mb_r);
          acc_nxt = {acc_r[126:0], 1'b1};
        end else begin
          rem_nxt = rem_sh;
          acc_nxt = {acc_r[126:0], 1'b0};
        end
        cnt_nxt = cnt_r + 7'd1;
        if (cnt_r == 7'd127) state_nxt = AL_FIN;
      end
      AL_SQRT: begin
        rem_sh = {rem_r[65:0], num_r[127:126]};
        trial = {2'b00, acc_r[63:0], 2'b01};
        num_nxt = num_r << 2;
        if (rem_sh >= trial) begin
          rem_nxt = rem_sh - trial;
          root = {acc_r[62:0], 1'b1};
        end else begin
          rem_nxt = rem_sh;
          root = {acc_r[62:0], 1'b0};
        end
        acc_nxt = 128'(root);
        cnt_nxt = cnt_r + 7'd1;
        if (cnt_r == 7'd63) state_nxt = AL_FIN;
      end
      AL_FIN: begin
        case (op_r)
          OP_MUL: begin
            wq = (acc_r + HALF_W) >> FRAC_BITS;
            fw = from_wide(wq, neg_r);
            res_nxt = fw[63:0];
            sat_nxt = fw[64];
          end
          OP_DIV: begin
            fw = from_wide(acc_r, neg_r);
            res_nxt = fw[63:0];
            sat_nxt = fw[64];
          end
          default: res_nxt = acc_r[63:0];
        endcase
        done_nxt = 1'b1;
        state_nxt = AL_IDLE;
      end
      default: state_nxt = AL_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= AL_IDLE;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r <= op_nxt;
    neg_r <= neg_nxt;
    ma_r <= ma_nxt;
    mb_r <= mb_nxt;
    acc_r <= acc_nxt;
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    res_r <= res_nxt;
    sat_r <= sat_nxt;
    zero_r <= zero_nxt;
  end

  assign rsp = '{done: done_r, result: res_r, sat: sat_r, zero: zero_r};

endmodule

[src/cr3_back.sv]
// microprogram sequencer with operand memory, jacobian store and output register
module cr3_back import cr3_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  cfg_t         cfg,
  input  logic         q_valid,
  input  qentry_t      q_entry,
  output logic         q_pop,
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [383:0] out_tdata,  // out_0 .. out_5
  output logic [2:0]   out_tuser   // result_kind, fault[1:0]
);

  back_state_t state_r, state_nxt;
  logic [7:0]  pc_r, pc_nxt;
  item_t       item_r;
  logic        zero_hit_r, zero_hit_nxt;
  logic        sat_hit_r, sat_hit_nxt;
  logic        jac_valid_r, jac_valid_nxt;
  logic [17:0] jac_wr_r, jac_wr_nxt;
  logic [2:0][63:0] res_r;
  logic        out_valid_r, out_valid_nxt;
  logic [383:0] out_data_r;
  logic [2:0]  out_user_r;

  logic [63:0] rf_mem [128];
  logic [63:0] rd_a_r, rd_b_r;
  logic        rf_we;
  logic [6:0]  jac_off, out_off;
  logic        load_item, load_out;
  logic [7:0]  pc_inc;
  logic [1:0]  fault_v;
  instr_t      instr;
  alu_req_t    alu_req;
  alu_rsp_t    alu_rsp;

  function automatic logic [63:0] operand(logic [6:0] src, logic [63:0] mem_q, item_t it,
                                          cfg_t c, logic [17:0] jw);
    logic [63:0] v;
    logic [6:0] off;
    off = src - R_JAC;
    if (src inside {[R_X:R_VZ]}) begin
      v = it.elem[src[2:0]];
    end else begin
      case (src)
        R_M:     v = {1'b0, it.mass};
        R_ZERO:  v = '0;
        R_ONE:   v = ONE_Q;
        R_TWO:   v = TWO_Q;
        R_MU:    v = {17'd0, c.mu};
        R_THR:   v = {16'd0, c.thr};
        default: begin
          if ((src inside {[R_JAC:R_JAC_LAST]}) && !jw[off[4:0]]) v = '0;
          else v = mem_q;
        end
      endcase
    end
    return v;
  endfunction

  cr3_alu u_alu (
    .clk(clk),
    .rst_n(rst_n),
    .req(alu_req),
    .rsp(alu_rsp)
  );

  assign instr = PROG[pc_r];
  assign pc_inc = pc_r + 8'd1;
  assign jac_off = instr.dst - R_JAC;
  assign out_off = instr.dst - R_OUT;

  always_comb begin
    if (item_r.action) fault_v = !jac_valid_r ? FAULT_ZERO : (sat_hit_r ? FAULT_SAT : FAULT_OK);
    else fault_v = zero_hit_r ? FAULT_ZERO : (sat_hit_r ? FAULT_SAT : FAULT_OK);
  end

  always_comb begin
    state_nxt = state_r;
    pc_nxt = pc_r;
    zero_hit_nxt = zero_hit_r;
    sat_hit_nxt = sat_hit_r;
    jac_valid_nxt = jac_valid_r;
    jac_wr_nxt = jac_wr_r;
    out_valid_nxt = out_valid_r && !out_tready;
    q_pop = 1'b0;
    load_item = 1'b0;
    load_out = 1'b0;
    rf_we = 1'b0;
    alu_req = '{start: 1'b0, op: instr.op,
                a: operand(instr.src_a, rd_a_r, item_r, cfg, jac_wr_r),
                b: operand(instr.src_b, rd_b_r, item_r, cfg, jac_wr_r)};
    case (state_r)
      B_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          load_item = 1'b1;
          pc_nxt = q_entry.start_pc;
          zero_hit_nxt = 1'b0;
          sat_hit_nxt = 1'b0;
          state_nxt = B_FETCH;
        end
      end
      B_FETCH: state_nxt = B_OPER;
      B_OPER: begin
        alu_req.start = 1'b1;
        state_nxt = B_EXEC;
      end
      B_EXEC: begin
        if (alu_rsp.done) begin
          rf_we = 1'b1;
          zero_hit_nxt = zero_hit_r | alu_rsp.zero;
          sat_hit_nxt = sat_hit_r | alu_rsp.sat;
          if (instr.dst inside {[R_JAC:R_JAC_LAST]}) jac_wr_nxt[jac_off[4:0]] = 1'b1;
          pc_nxt = pc_inc;
          state_nxt = (PROG[pc_inc].op == OP_END) ? B_DONE : B_FETCH;
        end
      end
      B_DONE: begin
        if (!out_valid_r || out_tready) begin
          load_out = 1'b1;
          out_valid_nxt = 1'b1;
          if (!item_r.action) jac_valid_nxt = !zero_hit_r;
          state_nxt = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      pc_r <= ST_START;
      zero_hit_r <= 1'b0;
      sat_hit_r <= 1'b0;
      jac_valid_r <= 1'b0;
      jac_wr_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pc_r <= pc_nxt;
      zero_hit_r <= zero_hit_nxt;
      sat_hit_r <= sat_hit_nxt;
      jac_valid_r <= jac_valid_nxt;
      jac_wr_r <= jac_wr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_item) item_r <= q_entry.item;
    if (rf_we && (instr.dst inside {[R_OUT:R_OUT_LAST]})) res_r[out_off[1:0]] <= alu_rsp.result;
    if (load_out) begin
      out_data_r <= {res_r[2], res_r[1], res_r[0],
                     item_r.elem[5], item_r.elem[4], item_r.elem[3]};
      out_user_r <= {fault_v, item_r.action};
    end
  end

  always_ff @(posedge clk) begin
    if (rf_we) rf_mem[instr.dst] <= alu_rsp.result;
    rd_a_r <= rf_mem[instr.src_a];
    rd_b_r <= rf_mem[instr.src_b];
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata = out_data_r;
  assign out_tuser = out_user_r;

endmodule

[src/cr3bp_low_thrust_derivative_core.sv]
// top level of the three-body low-thrust derivative core
// A state beat (tuser 0) returns the state derivative and stores the lower three jacobian
// rows; a column beat (tuser 1) returns the jacobian times that column. Beats are queued
// two deep in front of a microprogram sequencer that runs every operation through one
// shared arithmetic unit: add/sub, a multiply (four 32x32 partial products plus
// rounding), a divide (one quotient bit per cycle) and a square root (two radicand
// bits per cycle). A zero divisor skips the divide iterations.
module cr3bp_low_thrust_derivative_core import cr3_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [447:0] in_tdata,   // elem_0 .. elem_5, craft_mass, zero pad
  input  logic [0:0]   in_tuser,   // action
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [383:0] out_tdata,  // out_0 .. out_5
  output logic [2:0]   out_tuser,  // result_kind, fault[1:0]
  input  logic         cfg_we,
  input  logic [0:0]   cfg_index,
  input  logic [47:0]  cfg_wdata
);

  logic [46:0] mass_ratio_r, mass_ratio_nxt;
  logic [47:0] thrust_level_r, thrust_level_nxt;
  cfg_t        cfg;
  logic        q_valid;
  qentry_t     q_entry;
  logic        q_pop;

  always_comb begin
    mass_ratio_nxt = mass_ratio_r;
    thrust_level_nxt = thrust_level_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_MASS_RATIO:   mass_ratio_nxt = cfg_wdata[46:0];
        CFG_THRUST_LEVEL: thrust_level_nxt = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mass_ratio_r <= '0;
      thrust_level_r <= '0;
    end else begin
      mass_ratio_r <= mass_ratio_nxt;
      thrust_level_r <= thrust_level_nxt;
    end
  end

  assign cfg = '{mu: mass_ratio_r, thr: thrust_level_r};

  cr3_front u_front (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .q_valid(q_valid),
    .q_entry(q_entry),
    .q_pop(q_pop)
  );

  cr3_back u_back (
    .clk(clk),
    .rst_n(rst_n),
    .cfg(cfg),
    .q_valid(q_valid),
    .q_entry(q_entry),
    .q_pop(q_pop),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

endmodule

[test/tb_cr3bp_low_thrust_derivative_core.sv]
// self-checking testbench of the three-body low-thrust derivative core
`timescale 1ns / 1ps

module tb_cr3bp_low_thrust_derivative_core;
  import cr3_pkg::*;

  localparam int WATCH_LIMIT = 20000;
  localparam longint QMAX = 64'sh7fff_ffff_ffff_ffff;
  localparam longint QMIN = 64'sh8000_0000_0000_0000;
  localparam longint Q1 = 64'sh0000_8000_0000_0000;

  typedef struct packed {
    logic kind;
    logic [1:0] fault;
    logic [5:0][63:0] val;
  } deriv_t;

  typedef struct {
    bit wr_cfg;
    logic [46:0] mu;
    logic [47:0] thr;
    item_t it;
    bit typed;
    deriv_t want;
  } dir_row_t;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [447:0] in_tdata;
  logic [0:0] in_tuser;
  logic out_tvalid;
  logic out_tready;
  logic [383:0] out_tdata;
  logic [2:0] out_tuser;
  logic cfg_we;
  logic [0:0] cfg_index;
  logic [47:0] cfg_wdata;

  logic [46:0] mu_q;
  logic [47:0] thr_q;
  longint jac_rows [18];
  bit jac_ok;
  bit sat_f;
  bit zero_f;

  deriv_t deriv_q [$];
  dir_row_t dir_tab [$];
  int errors = 0;
  int tx_idle_pct;
  int rx_idle_pct;
  int hold_cycles;
  int quiet_cycles = 0;

  cr3bp_low_thrust_derivative_core u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // q16.47 arithmetic with saturation and zero-divisor flags
  function automatic logic [63:0] mag(longint a);
    return a < 0 ? 64'(-a) : 64'(a);
  endfunction

  function automatic longint from_mag(logic [63:0] m, bit neg);
    if (neg) begin
      if (m > 64'h8000_0000_0000_0000) begin
        sat_f = 1'b1;
        return QMIN;
      end
      return -longint'(m);
    end
    if (m[63]) begin
      sat_f = 1'b1;
      return QMAX;
    end
    return longint'(m);
  endfunction

  function automatic longint from_wide(logic [127:0] w, bit neg);
    if (w[127:64] != 0) begin
      sat_f = 1'b1;
      return neg ? QMIN : QMAX;
    end
    return from_mag(w[63:0], neg);
  endfunction

  function automatic longint q_add(longint a, longint b);
    longint r;
    r = a + b;
    if (a >= 0 && b >= 0 && r < 0) begin
      sat_f = 1'b1;
      return QMAX;
    end
    if (a < 0 && b < 0 && r >= 0) begin
      sat_f = 1'b1;
      return QMIN;
    end
    return r;
  endfunction

  function automatic longint q_sub(longint a, longint b);
    longint r;
    r = a - b;
    if (a >= 0 && b < 0 && r < 0) begin
      sat_f = 1'b1;
      return QMAX;
    end
    if (a < 0 && b >= 0 && r >= 0) begin
      sat_f = 1'b1;
      return QMIN;
    end
    return r;
  endfunction

  function automatic longint q_mul(longint a, longint b);
    logic [127:0] w;
    w = {64'd0, mag(a)} * {64'd0, mag(b)};
    w = (w + (128'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    return from_wide(w, (a < 0) != (b < 0));
  endfunction

  function automatic longint q_div(longint a, longint b);
    logic [127:0] w;
    if (b == 0) begin
      zero_f = 1'b1;
      return a < 0 ? QMIN : QMAX;
    end
    w = ({64'd0, mag(a)} << FRAC_BITS) / {64'd0, mag(b)};
    return from_wide(w, (a < 0) != (b < 0));
  endfunction

  function automatic longint q_sqrt(longint a);
    logic [127:0] n;
    logic [63:0] res;
    logic [63:0] cand;
    int k;
    if (a <= 0) return 0;
    n = {64'd0, 64'(a)} << FRAC_BITS;
    res = '0;
    for (k = 63; k >= 0; k--) begin
      cand = res | (64'd1 << k);
      if ({64'd0, cand} * {64'd0, cand} <= n) res = cand;
    end
    return longint'(res);
  endfunction

  // derivative of one beat; a state beat also refreshes the stored jacobian rows
  function automatic deriv_t derive(item_t it);
    deriv_t r;
    longint e [6];
    longint res [6];
    longint u [3];
    longint pd [3];
    longint pr [3];
    longint tj [3][3];
    longint two, mu, thr, mass, om, px, qx, yz2, dpri, rdist, spd, id, ir, iv, tm;
    longint id2, id3, id5, ir2, ir3, ir5, ga, gb, hd, hr, k1, k3, acc, g, t, s;
    int i;
    int j;
    sat_f = 1'b0;
    zero_f = 1'b0;
    for (i = 0; i < 6; i++) e[i] = longint'(it.elem[i]);
    r.kind = it.action;
    if (!it.action) begin
      two = q_add(Q1, Q1);
      mu = longint'({17'd0, mu_q});
      thr = longint'({16'd0, thr_q});
      mass = longint'({1'b0, it.mass});
      om = q_sub(Q1, mu);
      px = q_add(e[0], mu);
      qx = q_sub(px, Q1);
      u[0] = q_sub(e[3], e[1]);
      u[1] = q_add(e[4], e[0]);
      u[2] = e[5];
      pd[0] = px; pd[1] = e[1]; pd[2] = e[2];
      pr[0] = qx; pr[1] = e[1]; pr[2] = e[2];
      yz2 = q_add(q_mul(e[1], e[1]), q_mul(e[2], e[2]));
      dpri = q_sqrt(q_add(q_mul(px, px), yz2));
      rdist = q_sqrt(q_add(q_mul(qx, qx), yz2));
      spd = q_sqrt(q_add(q_add(q_mul(u[0], u[0]), q_mul(u[1], u[1])), q_mul(u[2], u[2])));
      id = q_div(Q1, dpri);
      ir = q_div(Q1, rdist);
      iv = q_div(Q1, spd);
      tm = q_div(thr, mass);
      id2 = q_mul(id, id); id3 = q_mul(id2, id); id5 = q_mul(id3, id2);
      ir2 = q_mul(ir, ir); ir3 = q_mul(ir2, ir); ir5 = q_mul(ir3, ir2);
      ga = q_mul(om, id3);
      gb = q_mul(mu, ir3);
      hd = q_mul(om, id5); hd = q_add(q_add(hd, hd), hd);
      hr = q_mul(mu, ir5); hr = q_add(q_add(hr, hr), hr);
      k1 = q_mul(tm, iv);
      k3 = q_mul(k1, q_mul(iv, iv));
      for (i = 0; i < 3; i++)
        for (j = 0; j < 3; j++) begin
          t = q_mul(k3, q_mul(u[i], u[j]));
          tj[i][j] = (i == j) ? q_sub(t, k1) : t;
        end
      for (i = 0; i < 3; i++) begin
        acc = 0;
        if (i == 0) acc = q_add(q_add(e[4], e[4]), e[0]);
        if (i == 1) acc = q_sub(e[1], q_add(e[3], e[3]));
        acc = q_sub(acc, q_mul(ga, pd[i]));
        acc = q_sub(acc, q_mul(gb, pr[i]));
        acc = q_sub(acc, q_mul(k1, u[i]));
        res[i] = e[i + 3];
        res[i + 3] = acc;
        for (j = 0; j < 6; j++) begin
          if (j < 3) begin
            g = q_add(q_mul(hd, q_mul(pd[i], pd[j])), q_mul(hr, q_mul(pr[i], pr[j])));
            if (i == j) begin
              g = q_sub(q_sub(g, ga), gb);
              if (i < 2) g = q_add(g, Q1);
            end
            if (j == 0) g = q_add(g, tj[i][1]);
            if (j == 1) g = q_sub(g, tj[i][0]);
          end else begin
            g = tj[i][j - 3];
            if (i == 0 && j == 4) g = q_add(g, two);
            if (i == 1 && j == 3) g = q_sub(g, two);
          end
          jac_rows[i * 6 + j] = g;
        end
      end
      jac_ok = !zero_f;
      r.fault = zero_f ? FAULT_ZERO : (sat_f ? FAULT_SAT : FAULT_OK);
    end else begin
      for (i = 0; i < 3; i++) begin
        s = 0;
        for (j = 0; j < 6; j++) s = q_add(s, q_mul(jac_rows[i * 6 + j], e[j]));
        res[i] = e[i + 3];
        res[i + 3] = s;
      end
      r.fault = !jac_ok ? FAULT_ZERO : (sat_f ? FAULT_SAT : FAULT_OK);
    end
    for (i = 0; i < 6; i++) r.val[i] = 64'(res[i]);
    return r;
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // result beat check and watchdog
  always @(posedge clk) begin
    deriv_t w;
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > WATCH_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
      if (out_tvalid && out_tready) begin
        if (deriv_q.size() == 0) begin
          report("unexpected beat", {61'd0, out_tuser}, '0);
        end else begin
          w = deriv_q.pop_front();
          if (out_tuser[0] !== w.kind)
            report("result_kind", 64'(out_tuser[0]), 64'(w.kind));
          if (out_tuser[2:1] !== w.fault)
            report("fault", 64'(out_tuser[2:1]), 64'(w.fault));
          for (int k = 0; k < 6; k++)
            if (out_tdata[k*64 +: 64] !== w.val[k])
              report($sformatf("out_%0d", k), out_tdata[k*64 +: 64], w.val[k]);
        end
      end
    end
  end

  // receiver: random stalls plus an optional long hold-off
  initial begin
    int hold_left;
    bit held;
    hold_left = 0;
    held = 1'b0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && hold_cycles > 0) begin
        held = 1'b1;
        hold_left = hold_cycles;
      end
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  task automatic send_beat(item_t it, bit typed, deriv_t want);
    deriv_t p;
    @(negedge clk);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {1'b0, it.mass, it.elem};
    in_tuser <= it.action;
    do @(posedge clk); while (!in_tready);
    p = derive(it);
    if (typed) p = want;
    deriv_q = {deriv_q, p};
  endtask

  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (deriv_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_cfg(logic [46:0] mu, logic [47:0] thr);
    drain();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_MASS_RATIO;
    cfg_wdata <= {1'b0, mu};
    @(negedge clk);
    cfg_index <= CFG_THRUST_LEVEL;
    cfg_wdata <= thr;
    @(negedge clk);
    cfg_we <= 1'b0;
    mu_q = mu;
    thr_q = thr;
  endtask

  function automatic logic [63:0] near_val();
    return 64'(longint'({$urandom, $urandom}) >>> 15);
  endfunction

  function automatic logic [63:0] any_val();
    return {$urandom, $urandom};
  endfunction

  function automatic item_t state_beat(longint x, longint y, longint z, longint vx,
                                       longint vy, longint vz, logic [62:0] m);
    item_t it;
    it.action = 1'b0;
    it.elem = {64'(vz), 64'(vy), 64'(vx), 64'(z), 64'(y), 64'(x)};
    it.mass = m;
    return it;
  endfunction

  function automatic item_t col_beat(longint c0, longint c1, longint c2, longint c3,
                                     longint c4, longint c5);
    item_t it;
    it = state_beat(c0, c1, c2, c3, c4, c5, '0);
    it.action = 1'b1;
    return it;
  endfunction

  task automatic add_row(item_t it);
    dir_row_t r;
    r.wr_cfg = 1'b0;
    r.mu = '0;
    r.thr = '0;
    r.it = it;
    r.typed = 1'b0;
    r.want = '0;
    dir_tab = {dir_tab, r};
  endtask

  task automatic add_cfg_row(logic [46:0] mu, logic [47:0] thr, item_t it);
    add_row(it);
    dir_tab[$].wr_cfg = 1'b1;
    dir_tab[$].mu = mu;
    dir_tab[$].thr = thr;
  endtask

  task automatic random_run(int n_beats);
    item_t it;
    int sent;
    int ncol;
    sent = 0;
    while (sent < n_beats) begin
      if ($urandom_range(0, 9) != 0)
        it = state_beat(near_val(), near_val() >>> 1, near_val() >>> 2, near_val() >>> 1,
                        near_val() >>> 1, near_val() >>> 2, 63'($urandom_range(1, 255)) << 40);
      else begin
        it.action = 1'b0;
        for (int k = 0; k < 6; k++)
          it.elem[k] = ($urandom_range(0, 3) == 0) ? 64'd0 : any_val();
        it.mass = ($urandom_range(0, 3) == 0) ? 63'd0 : 63'(any_val());
      end
      if ($urandom_range(0, 19) == 0) it.action = 1'b1;
      send_beat(it, 1'b0, '0);
      sent++;
      ncol = $urandom_range(1, 6);
      for (int c = 0; c < ncol && sent < n_beats; c++) begin
        it.action = 1'b1;
        for (int k = 0; k < 6; k++)
          it.elem[k] = ($urandom_range(0, 9) < 7) ? near_val() : any_val();
        it.mass = 63'(any_val());
        send_beat(it, 1'b0, '0);
        sent++;
      end
    end
  endtask

  initial begin
    item_t nom;
    deriv_t w;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    hold_cycles = 0;
    tx_idle_pct = 19;
    rx_idle_pct = 53;
    mu_q = '0;
    thr_q = '0;
    jac_ok = 1'b0;
    for (int k = 0; k < 18; k++) jac_rows[k] = 0;

    nom = state_beat(Q1 * 4 / 5, Q1 / 10, Q1 / 20, Q1 / 50, Q1 * 3 / 10, Q1 / 100, 63'(Q1));

    // column before any state: zero jacobian, no valid rows
    add_row(col_beat(Q1, 2 * Q1, 3 * Q1, 4 * Q1, 5 * Q1, 6 * Q1));
    w.kind = 1'b1;
    w.fault = FAULT_ZERO;
    w.val = {64'd0, 64'd0, 64'd0, 64'(6 * Q1), 64'(5 * Q1), 64'(4 * Q1)};
    dir_tab[$].typed = 1'b1;
    dir_tab[$].want = w;
    add_row(state_beat(0, 0, 0, 0, 0, 0, '0));
    add_row(col_beat(Q1, -Q1, Q1, -Q1, Q1, -Q1));
    add_cfg_row(47'(Q1 >>> 6), 48'(Q1 >>> 8), nom);
    add_row(col_beat(Q1, 0, 0, 0, 0, 0));
    add_row(col_beat(0, 0, 0, Q1, 0, 0));
    add_row(col_beat(QMAX, QMAX, QMAX, QMAX, QMAX, QMAX));
    add_row(col_beat(QMIN, QMIN, QMIN, QMIN, QMIN, QMIN));
    add_row(state_beat(Q1 * 4 / 5, Q1 / 10, 0, 0, Q1, 0, '0));
    add_row(state_beat(Q1 / 2, Q1 / 4, 0, Q1 / 4, -Q1 / 2, 0, 63'(Q1)));
    add_row(col_beat(Q1, Q1, Q1, Q1, Q1, Q1));
    add_row(state_beat(QMAX, QMAX, QMAX, QMAX, QMAX, QMAX, {63{1'b1}}));
    add_row(state_beat(QMIN, QMIN, QMIN, QMIN, QMIN, QMIN, 63'(Q1)));
    add_row(state_beat(Q1 - (Q1 >>> 6), 0, 0, Q1 / 10, Q1 / 10, 0, 63'(Q1)));
    add_row(col_beat(Q1 / 3, Q1 / 5, Q1 / 7, Q1 / 11, Q1 / 13, Q1 / 17));
    add_cfg_row({47{1'b1}}, {48{1'b1}}, nom);
    add_row(col_beat(Q1, Q1 / 2, -Q1, Q1 / 4, -Q1 / 8, Q1 / 16));
    add_cfg_row('0, '0, nom);
    add_row(col_beat(-Q1, Q1 / 2, Q1, -Q1 / 4, Q1 / 8, -Q1 / 16));

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_tab[r]) begin
      if (dir_tab[r].wr_cfg) write_cfg(dir_tab[r].mu, dir_tab[r].thr);
      send_beat(dir_tab[r].it, dir_tab[r].typed, dir_tab[r].want);
    end

    write_cfg(47'(Q1 / 82), 48'($urandom_range(1, 1 << 16)) << 30);
    hold_cycles = 3000;
    random_run(250);

    write_cfg({47{1'b1}}, {48{1'b1}});
    tx_idle_pct = 53;
    rx_idle_pct = 19;
    random_run(120);
    drain();
    random_run(130);

    write_cfg(47'($urandom_range(0, 1 << 30)) << 16, '0);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    random_run(250);

    drain();
    repeat (100) @(posedge clk);
    if (errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule

[sim.f]
src/cr3_pkg.sv
src/cr3_front.sv
src/cr3_alu.sv
src/cr3_back.sv
src/cr3bp_low_thrust_derivative_core.sv
test/tb_cr3bp_low_thrust_derivative_core.sv
